// File: rtl/heat_diffusion_stencil_step_assert.svh
// Assertion macros shared by the heat diffusion checker.
`ifndef HEAT_DIFFUSION_STENCIL_STEP_ASSERT_SVH
`define HEAT_DIFFUSION_STENCIL_STEP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define HDS_ASSERT_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an expression on the edge that follows an edge with reset asserted.
`define HDS_ASSERT_RESET(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) !rst_n |=> (expr)) else $error(msg);

`endif

// File: rtl/hds_pkg.sv
// Shared constants and types of the heat diffusion stencil step.
`default_nettype none

package hds_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int CNT_W      = COL_W + 1;
    localparam int TEMP_W     = 32;
    localparam int ROW_W      = 16;
    localparam int COLS_CFG_W = 11;
    localparam int RATIO_W    = 15;
    localparam int RATIO_FRAC = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_DIM    = 3;
    localparam int INNER_LO   = 2;

    // Column compare width: covers the register and the column count.
    localparam int CMP_W   = (COLS_CFG_W > CNT_W) ? COLS_CFG_W : CNT_W;
    // Datapath widths: pair sum, Laplacian, product, shifted delta, final sum.
    localparam int PAIR_W  = TEMP_W + 1;
    localparam int LAP_W   = TEMP_W + 3;
    localparam int PROD_W  = LAP_W + RATIO_W + 1;
    localparam int DELTA_W = PROD_W - RATIO_FRAC;
    localparam int SUM_W   = DELTA_W + 1;

    localparam logic [COLS_CFG_W-1:0] COLS_RST  = COLS_CFG_W'(1024);
    localparam logic [ROW_W-1:0]      ROWS_RST  = ROW_W'(1000);
    localparam logic [RATIO_W-1:0]    RATIO_RST = RATIO_W'(655);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS  = 2'd0,
        CFG_ROWS  = 2'd1,
        CFG_RATIO = 2'd2
    } t_cfg_idx;

    typedef logic signed [TEMP_W-1:0] t_temp;

endpackage

`default_nettype wire

// File: rtl/hds_line_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none

module hds_line_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/heat_diffusion_stencil_step.sv
// An accepted cell passes through stages 1 to 4 and then the output register before its result shows.
// Throughput: one cell per cycle while the output is not stalled; the line RAM is read once and written once per cell.
// The pipeline moves only into free stages, so bubbles absorb output stalls.
// Reset (synchronous, active low) clears positions and valids and loads the config registers with their defaults.
// Line RAM contents are not cleared; stale entries are read only for boundary cells, which give no result.
`default_nettype none

module heat_diffusion_stencil_step
    import hds_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // cell stream in
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic signed [TEMP_W-1:0] i_temperature,
    // result stream out
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic signed [TEMP_W-1:0]   o_new_temperature,
    output logic                       o_last_of_plate,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COLS_CFG_W-1:0] r_cols;
    logic [ROW_W-1:0]      r_rows;
    logic [RATIO_W-1:0]    r_ratio;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= COLS_RST;
            r_rows  <= ROWS_RST;
            r_ratio <= RATIO_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COLS:  r_cols  <= i_cfg_data[COLS_CFG_W-1:0];
                CFG_ROWS:  r_rows  <= i_cfg_data[ROW_W-1:0];
                CFG_RATIO: r_ratio <= i_cfg_data[RATIO_W-1:0];
                default:   ;
            endcase
        end
    end

    // Clamp plate geometry: columns to what the line RAM can hold and at least MIN_DIM, rows to at least MIN_DIM.
    logic [CMP_W-1:0] cols_raw;
    logic [CMP_W-1:0] cols_eff;
    logic [ROW_W-1:0] rows_eff;

    always_comb begin
        cols_raw = CMP_W'(r_cols);
        priority if (cols_raw < CMP_W'(MIN_DIM)) begin
            cols_eff = CMP_W'(MIN_DIM);
        end else if (cols_raw > CMP_W'(MAX_COLS)) begin
            cols_eff = CMP_W'(MAX_COLS);
        end else begin
            cols_eff = cols_raw;
        end
        rows_eff = (r_rows < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : r_rows;
    end

    // ------------------------------------------------------------------
    // Handshake: each stage loads when it is empty or its content moves on.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic out_rdy, s4_rdy, s3_rdy, s2_rdy, s1_rdy;
    logic in_acc, s1_fire;

    assign out_rdy    = !r_out_valid || !i_out_stall;
    assign s4_rdy     = !r_v4 || out_rdy;
    assign s3_rdy     = !r_v3 || s4_rdy;
    assign s2_rdy     = !r_v2 || s3_rdy;
    assign s1_rdy     = !r_v1 || s2_rdy;
    assign o_in_stall = !s1_rdy;
    assign in_acc     = i_in_valid && s1_rdy;
    assign s1_fire    = r_v1 && s2_rdy;

    // ------------------------------------------------------------------
    // Raster position and interior test at acceptance
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] col_nxt;
    logic [ROW_W:0]   row_nxt;
    logic             emit;
    logic             last;

    always_comb begin
        col_ext = CMP_W'(r_col);
        col_nxt = col_ext + CMP_W'(1);
        row_nxt = {1'b0, r_row} + (ROW_W + 1)'(1);
        emit    = (r_row >= ROW_W'(INNER_LO)) && (r_row < rows_eff)
               && (col_ext >= CMP_W'(INNER_LO)) && (col_ext < cols_eff);
        last    = (r_row == rows_eff - ROW_W'(1)) && (col_ext == cols_eff - CMP_W'(1));
    end

    // Advance column, wrap to the next row, wrap the plate to row zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (col_nxt >= cols_eff) begin
                r_col <= '0;
                r_row <= (row_nxt >= (ROW_W + 1)'(rows_eff)) ? '0 : row_nxt[ROW_W-1:0];
            end else begin
                r_col <= col_nxt[COL_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Line RAM: one entry per column holds {upper row, middle row}.
    // Read at acceptance, written back when the cell leaves stage 1.
    // Consecutive transactions always address different columns, and an
    // entry is read again no sooner than the third transaction after, so
    // the write-back always lands before the next read of the same entry.
    // ------------------------------------------------------------------
    logic [2*TEMP_W-1:0] ram_rd;
    logic [2*TEMP_W-1:0] ram_wr;
    t_temp               rd_up;
    t_temp               rd_mid;

    logic [COL_W-1:0] r_s1_col;
    t_temp            r_s1_cell;
    logic             r_s1_emit;
    logic             r_s1_last;

    assign rd_up  = $signed(ram_rd[2*TEMP_W-1:TEMP_W]);
    assign rd_mid = $signed(ram_rd[TEMP_W-1:0]);
    // Shift the column up: middle row becomes upper, new cell becomes middle.
    assign ram_wr = {rd_mid, r_s1_cell};

    hds_line_ram #(
        .WIDTH (2 * TEMP_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (ram_rd),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_col),
        .i_wr_data (ram_wr)
    );

    // ------------------------------------------------------------------
    // Stage 1: cell waits for its column from the RAM.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_rdy) begin
            r_v1 <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_col  <= r_col;
            r_s1_cell <= i_temperature;
            r_s1_emit <= emit;
            r_s1_last <= last;
        end
    end

    // Sliding 3x3 window, kept only where the stencil looks:
    // r_win_up / r_win_dn are top and bottom of the newest column,
    // r_win_ml / r_win_mr are the middle row of the two newest columns.
    t_temp r_win_up;
    t_temp r_win_ml;
    t_temp r_win_mr;
    t_temp r_win_dn;

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_win_up <= rd_up;
            r_win_ml <= r_win_mr;
            r_win_mr <= rd_mid;
            r_win_dn <= r_s1_cell;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: vertical and horizontal neighbor pairs.
    // After the shift the center is the old right-middle entry.
    // ------------------------------------------------------------------
    logic signed [PAIR_W-1:0] r_s2_vert;
    logic signed [PAIR_W-1:0] r_s2_horz;
    t_temp                    r_s2_ctr;
    logic                     r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s2_rdy) begin
            // drop boundary cells here: they give no result
            r_v2 <= r_v1 && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy) begin
            r_s2_vert <= PAIR_W'(r_win_up) + PAIR_W'(r_win_dn);
            r_s2_horz <= PAIR_W'(r_win_ml) + PAIR_W'(rd_mid);
            r_s2_ctr  <= r_win_mr;
            r_s2_last <= r_s1_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: exact Laplacian, neighbors minus four times the center.
    // ------------------------------------------------------------------
    logic signed [LAP_W-1:0] r_s3_lap;
    t_temp                   r_s3_ctr;
    logic                    r_s3_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (s3_rdy) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_rdy) begin
            r_s3_lap  <= LAP_W'(r_s2_vert) + LAP_W'(r_s2_horz)
                       - (LAP_W'(r_s2_ctr) <<< 2);
            r_s3_ctr  <= r_s2_ctr;
            r_s3_last <= r_s2_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale by the diffusion ratio (unsigned Q0.16).
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] r_s4_prod;
    t_temp                    r_s4_ctr;
    logic                     r_s4_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (s4_rdy) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_rdy) begin
            r_s4_prod <= PROD_W'(r_s3_lap) * PROD_W'($signed({1'b0, r_ratio}));
            r_s4_ctr  <= r_s3_ctr;
            r_s4_last <= r_s3_last;
        end
    end

    // ------------------------------------------------------------------
    // Output register: floor-shift the product, add to center, saturate.
    // ------------------------------------------------------------------
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - TEMP_W + 1){1'b0}}, {(TEMP_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W - TEMP_W + 1){1'b1}}, {(TEMP_W - 1){1'b0}}};

    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum;
    t_temp                     sat;
    t_temp                     r_out_temp;
    logic                      r_out_last;

    always_comb begin
        delta = DELTA_W'(r_s4_prod >>> RATIO_FRAC);
        sum   = SUM_W'(r_s4_ctr) + SUM_W'(delta);
        priority if (sum > SAT_HI) begin
            sat = TEMP_W'(SAT_HI);
        end else if (sum < SAT_LO) begin
            sat = TEMP_W'(SAT_LO);
        end else begin
            sat = TEMP_W'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_rdy) begin
            r_out_valid <= r_v4;
        end
    end

    // Hold the result while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_out_temp <= sat;
            r_out_last <= r_s4_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_new_temperature = r_out_temp;
    assign o_last_of_plate   = r_out_last;

endmodule

`default_nettype wire

// File: rtl/hds_checker.sv
// Port-level checker for the heat diffusion stencil step, bound to the top level.
`default_nettype none
`include "heat_diffusion_stencil_step_assert.svh"

module hds_checker
    import hds_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_in_stall,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_stall,
    input wire logic signed [TEMP_W-1:0] o_new_temperature,
    input wire logic                     o_last_of_plate
);

    // A stalled result transaction holds.
    `HDS_ASSERT_ON(out_hold_a, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_new_temperature) && $stable(o_last_of_plate), "result changed while stalled")

    // The input side backs up only when the output side is blocked.
    `HDS_ASSERT_ON(in_stall_cause_a, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall, "input stalled with output free")

    // Reset empties the pipeline.
    `HDS_ASSERT_RESET(out_idle_after_reset_a, i_clk, i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind heat_diffusion_stencil_step hds_checker u_hds_checker (.*);

`default_nettype wire

// File: tb/sv/heat_diffusion_stencil_step_test.sv
// Self-checking testbench for the five-point heat diffusion stencil step.
`default_nettype none

module heat_diffusion_stencil_step_test;
    import hds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Base figure for the settle time, and how long to let the pipeline settle.
    localparam int LATENCY        = 4;
    localparam int SETTLE_CYCLES  = 2 * LATENCY + 4;
    // Receiver hold-off length used to back the block up into its input.
    localparam int HOLD_CYCLES    = 300;
    // Cycles with no transaction on any channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BUSY_PCT       = 84;
    localparam int BOTH_PCT       = 12;
    localparam int MAX_REPORTS    = 30;

    localparam longint TEMP_MAX = (longint'(1) <<< (TEMP_W - 1)) - 1;
    localparam longint TEMP_MIN = -TEMP_MAX - 1;
    localparam t_temp  TEMP_TOP    = {1'b0, {(TEMP_W - 1){1'b1}}};
    localparam t_temp  TEMP_BOTTOM = {1'b1, {(TEMP_W - 1){1'b0}}};

    // Index with no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    typedef enum {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH,
        PACE_HOLDOFF
    } t_pace;

    typedef enum {
        FILL_SMOOTH,
        FILL_NOISE,
        FILL_EXTREME
    } t_fill;

    typedef struct packed {
        t_temp temp;
        logic  last;
    } t_plate_result;

    // DUT connections; every input starts at a known value.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_temp                 i_temperature = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_temp                 o_new_temperature;
    logic                  o_last_of_plate;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_COLS;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Cells waiting to be offered, and updated cells waiting to come out.
    t_temp         cell_feed[$];
    t_plate_result predicted_cells[$];

    // Shadow of the configuration registers as the block holds them.
    logic [COLS_CFG_W-1:0] cols_reg  = COLS_RST;
    logic [ROW_W-1:0]      rows_reg  = ROWS_RST;
    logic [RATIO_W-1:0]    ratio_reg = RATIO_RST;

    // Predictor state: two line buffers, the 3x3 window and the raster position.
    t_temp upper_row[MAX_COLS];
    t_temp middle_row[MAX_COLS];
    t_temp win[9];
    int    row_pos;
    int    col_pos;

    t_pace idle_pace = PACE_FULL;
    int    hold_count = 0;
    int    quiet_cycles = 0;
    int    mismatches = 0;
    int    fed = 0;

    heat_diffusion_stencil_step u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_temperature     (i_temperature),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_new_temperature (o_new_temperature),
        .o_last_of_plate   (o_last_of_plate),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Effective plate geometry: out-of-range register values clamp.
    function automatic int plate_cols();
        if (cols_reg < MIN_DIM) return MIN_DIM;
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return int'(cols_reg);
    endfunction

    function automatic int plate_rows();
        if (rows_reg < MIN_DIM) return MIN_DIM;
        return int'(rows_reg);
    endfunction

    // Advance the stencil by one cell and queue the updated interior cell, if any.
    function automatic void predict_cell(input t_temp new_cell);
        int            ncols;
        int            nrows;
        t_temp         above;
        t_temp         mid;
        longint        lap;
        longint        delta;
        longint        sum;
        t_plate_result res;
        ncols = plate_cols();
        nrows = plate_rows();
        // Read both lines at this column, then shift the column up by one row.
        above = upper_row[col_pos];
        mid   = middle_row[col_pos];
        upper_row[col_pos]  = mid;
        middle_row[col_pos] = new_cell;
        // Slide the window one column left and load the new right column.
        win[0] = win[1];
        win[1] = win[2];
        win[3] = win[4];
        win[4] = win[5];
        win[6] = win[7];
        win[7] = win[8];
        win[2] = above;
        win[5] = mid;
        win[8] = new_cell;
        // The center is one row up and one column left of the arriving cell.
        if (row_pos >= INNER_LO && row_pos < nrows
                && col_pos >= INNER_LO && col_pos < ncols) begin
            lap = longint'(win[1]) + longint'(win[7]) + longint'(win[3])
                + longint'(win[5]) - 4 * longint'(win[4]);
            // Floor the scaled Laplacian, then saturate the sum with the center.
            delta = (lap * longint'(ratio_reg)) >>> RATIO_FRAC;
            sum = longint'(win[4]) + delta;
            if (sum > TEMP_MAX) sum = TEMP_MAX;
            if (sum < TEMP_MIN) sum = TEMP_MIN;
            res.temp = t_temp'(sum);
            res.last = (row_pos == nrows - 1) && (col_pos == ncols - 1);
            predicted_cells.push_back(res);
        end
        // Wrap to the next row, and to the next plate after the last cell.
        col_pos++;
        if (col_pos >= ncols) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= nrows) row_pos = 0;
        end
    endfunction

    function automatic bit sender_rests();
        case (idle_pace)
            PACE_SEND_IDLE: return $urandom_range(99) < BUSY_PCT;
            PACE_BOTH:      return $urandom_range(99) < BOTH_PCT;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_pace)
            PACE_RECV_STALL: return $urandom_range(99) < BUSY_PCT;
            PACE_BOTH:       return $urandom_range(99) < BOTH_PCT;
            PACE_HOLDOFF:    return hold_count < HOLD_CYCLES;
            default:         return 1'b0;
        endcase
    endfunction

    // Cell source: hold the payload while stalled, predict on each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) predict_cell(i_temperature);
            if (!i_in_valid || !o_in_stall) begin
                if (cell_feed.size() != 0 && !sender_rests()) begin
                    i_in_valid    <= 1'b1;
                    i_temperature <= cell_feed.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_result();
        t_plate_result want;
        if (predicted_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: unexpected result: expected none, got temp %0d last %0b",
                         $time, o_new_temperature, o_last_of_plate);
        end else begin
            want = predicted_cells.pop_front();
            if (want.temp !== o_new_temperature) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: new_temperature mismatch: expected %0d, got %0d",
                             $time, want.temp, o_new_temperature);
            end
            if (want.last !== o_last_of_plate) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: last_of_plate mismatch: expected %0b, got %0b",
                             $time, want.last, o_last_of_plate);
            end
        end
    endtask

    // Result sink: check each accepted transaction, then pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_result();
        // Count the hold-off in this process so it starts when the phase does.
        if (idle_pace == PACE_HOLDOFF) begin
            if (hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
        end else begin
            hold_count <= 0;
        end
        i_out_stall <= receiver_stalls();
    end

    // Watchdog: end the run if no channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[heat_diffusion_stencil_step] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Issue one register write and mirror it once the transaction completes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_COLS:  cols_reg  = data[COLS_CFG_W-1:0];
            CFG_ROWS:  rows_reg  = data[ROW_W-1:0];
            CFG_RATIO: ratio_reg = data[RATIO_W-1:0];
            default: ;
        endcase
    endtask

    // Put random junk above the register width so the unused bits toggle too.
    function automatic logic [CFG_DATA_W-1:0] cfg_word(input int value, input int width);
        int mask;
        mask = (1 << width) - 1;
        return CFG_DATA_W'(($urandom & ~mask) | (value & mask));
    endfunction

    // Wait until every cell is in and every update is out, then let the pipe empty.
    task automatic drain();
        while (cell_feed.size() != 0 || i_in_valid || predicted_cells.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_temp pick_temp(input t_fill style, input t_temp base);
        case (style)
            FILL_SMOOTH: return base + t_temp'($urandom_range(8191)) - t_temp'(4096);
            FILL_NOISE:  return t_temp'($urandom);
            default: begin
                case ($urandom_range(3))
                    0:       return TEMP_TOP;
                    1:       return TEMP_BOTTOM;
                    2:       return '0;
                    default: return t_temp'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic t_fill random_fill();
        int p;
        p = $urandom_range(99);
        if (p < 50) return FILL_SMOOTH;
        if (p < 80) return FILL_NOISE;
        return FILL_EXTREME;
    endfunction

    // Queue one whole plate for the current geometry.
    task automatic queue_plate(input t_fill style);
        int    n;
        t_temp base;
        base = t_temp'($urandom) >>> 7;
        n = plate_cols() * plate_rows();
        repeat (n) cell_feed.push_back(pick_temp(style, base));
        fed += n;
    endtask

    // Queue a 3x3 plate: uniform ring around a different center.
    task automatic queue_pinned(input t_temp ring, input t_temp hub);
        for (int k = 0; k < 9; k++) cell_feed.push_back(k == 4 ? hub : ring);
        fed += 9;
    endtask

    // Rewrite some registers; mostly small plates, now and then clamped or unstable values.
    task automatic retune(input bit all);
        int p;
        if (all || $urandom_range(99) < 60) begin
            p = $urandom_range(99);
            if (p < 70)      write_reg(CFG_COLS, cfg_word($urandom_range(24, 3), COLS_CFG_W));
            else if (p < 85) write_reg(CFG_COLS, cfg_word($urandom_range(2, 0), COLS_CFG_W));
            else             write_reg(CFG_COLS, cfg_word($urandom_range(64, 25), COLS_CFG_W));
        end
        if (all || $urandom_range(99) < 60) begin
            p = $urandom_range(99);
            if (p < 75)      write_reg(CFG_ROWS, cfg_word($urandom_range(10, 3), ROW_W));
            else if (p < 90) write_reg(CFG_ROWS, cfg_word($urandom_range(2, 0), ROW_W));
            else             write_reg(CFG_ROWS, cfg_word($urandom_range(20, 11), ROW_W));
        end
        if (all || $urandom_range(99) < 60) begin
            p = $urandom_range(99);
            if (p < 55)      write_reg(CFG_RATIO, cfg_word($urandom_range(16384, 0), RATIO_W));
            else if (p < 70) write_reg(CFG_RATIO, cfg_word(16384, RATIO_W));
            else if (p < 80) write_reg(CFG_RATIO, cfg_word(0, RATIO_W));
            else             write_reg(CFG_RATIO, cfg_word($urandom_range(32767, 16385), RATIO_W));
        end
    endtask

    // Run rounds of back-to-back plates under one pacing until the cell budget is spent.
    task automatic run_rounds(input t_pace pace, input int budget);
        int start;
        idle_pace <= pace;
        start = fed;
        retune(1'b1);
        while (fed - start < budget) begin
            repeat ($urandom_range(3, 1)) queue_plate(random_fill());
            drain();
            retune(1'b0);
        end
    endtask

    initial begin
        // Clear the predictor state; the block's reset clears positions, not its line RAM.
        for (int k = 0; k < MAX_COLS; k++) begin
            upper_row[k]  = '0;
            middle_row[k] = '0;
        end
        for (int k = 0; k < 9; k++) win[k] = '0;
        row_pos = 0;
        col_pos = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: smallest plate via clamped geometry, widest ratio field.
        write_reg(CFG_COLS, 16'hA800);
        write_reg(CFG_ROWS, 16'd2);
        write_reg(CFG_RATIO, 16'hFFFF);
        // Saturate upward, then downward on the plate that follows right after the wrap.
        queue_pinned(TEMP_TOP, TEMP_BOTTOM);
        queue_pinned(TEMP_BOTTOM, TEMP_TOP);
        drain();
        // Zero ratio must hand the center back unchanged.
        write_reg(CFG_RATIO, 16'd0);
        queue_plate(FILL_NOISE);
        drain();
        // A write to the unused index must leave every register alone.
        write_reg(CFG_SPARE, 16'($urandom));
        queue_plate(FILL_EXTREME);
        drain();

        // Full rate: wide plate, then tall plate.
        idle_pace <= PACE_FULL;
        write_reg(CFG_COLS, 16'd100);
        write_reg(CFG_ROWS, 16'd3);
        write_reg(CFG_RATIO, 16'd16384);
        queue_plate(FILL_SMOOTH);
        drain();
        write_reg(CFG_COLS, 16'd3);
        write_reg(CFG_ROWS, 16'd30);
        queue_plate(FILL_SMOOTH);
        drain();
        run_rounds(PACE_FULL, 120);

        // Hold the receiver off while cells keep coming, so the block backs up.
        idle_pace <= PACE_HOLDOFF;
        write_reg(CFG_COLS, 16'd12);
        write_reg(CFG_ROWS, 16'd10);
        queue_plate(FILL_SMOOTH);
        drain();

        run_rounds(PACE_SEND_IDLE, 120);
        run_rounds(PACE_RECV_STALL, 120);
        run_rounds(PACE_BOTH, 120);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && predicted_cells.size() == 0) begin
            $display("[heat_diffusion_stencil_step] OK");
        end else begin
            $display("[heat_diffusion_stencil_step] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
